// File: rtl/rmq_pkg.sv
// ----------------------------------------------------------------------------
// rmq_pkg: shared types and constants for the rotation-matrix to quaternion unit
// Field widths, saturation limits, branch codes, register map and cell defaults.
// ----------------------------------------------------------------------------
package rmq_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int FIELD_W       = 18;
    localparam int MAG_W         = 19;
    localparam int THR_W         = 17;
    localparam int LANES         = 3;
    localparam int ADDR_W        = 3;
    localparam int DATA_W        = 32;

    // Default cell sizes for the default fraction width
    localparam int ROOT_W_DEF    = 19;
    localparam int QUO_W_DEF     = MAG_W + FRAC_BITS_DEF;

    localparam int SAT_MAX       = 131071;
    localparam int SAT_MIN_MAG   = 131072;
    localparam logic signed [FIELD_W-1:0] Q_MAX = FIELD_W'(SAT_MAX);
    localparam logic signed [FIELD_W-1:0] Q_MIN = FIELD_W'(-SAT_MIN_MAG);

    // Register map: index bit is paddr[ADDR_W-1]
    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    typedef enum logic [1:0] {
        BR_TRACE = 2'd0,
        BR_X     = 2'd1,
        BR_Y     = 2'd2,
        BR_Z     = 2'd3
    } t_branch;

    typedef struct packed {
        t_branch          branch;
        logic [LANES-1:0] neg;
        logic             degen;
    } t_tag;

endpackage

// File: rtl/rmq_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rmq_sqrt_cell: one root bit of a restoring square root
// Takes two radicand bits, decides one root bit and hands the rest onward.
// ----------------------------------------------------------------------------
module rmq_sqrt_cell #(
    parameter int ROOT_W = rmq_pkg::ROOT_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_en,
    input  logic [ROOT_W+1:0]     i_rem,
    input  logic [ROOT_W-1:0]     i_root,
    input  logic [2*ROOT_W-1:0]   i_rad,
    output logic [ROOT_W+1:0]     o_rem,
    output logic [ROOT_W-1:0]     o_root,
    output logic [2*ROOT_W-1:0]   o_rad
);
    localparam int REM_W = ROOT_W + 2;

    logic [REM_W+1:0]    w_cat;
    logic [REM_W+2:0]    w_diff;
    logic [REM_W-1:0]    n_rem,  r_rem;
    logic [ROOT_W-1:0]   n_root, r_root;
    logic [2*ROOT_W-1:0] n_rad,  r_rad;

    always_comb begin
        w_cat  = {i_rem, i_rad[2*ROOT_W-1 -: 2]};
        w_diff = {1'b0, w_cat} - (REM_W+3)'({i_root, 2'b01});
        if (!w_diff[REM_W+2]) begin
            n_rem  = w_diff[REM_W-1:0];
            n_root = {i_root[ROOT_W-2:0], 1'b1};
        end else begin
            n_rem  = w_cat[REM_W-1:0];
            n_root = {i_root[ROOT_W-2:0], 1'b0};
        end
        n_rad = {i_rad[2*ROOT_W-3:0], 2'b00};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= n_rad;
        end
    end

    assign o_rem  = r_rem;
    assign o_root = r_root;
    assign o_rad  = r_rad;

endmodule

// File: rtl/rmq_div_cell.sv
// ----------------------------------------------------------------------------
// rmq_div_cell: one quotient bit of a restoring divider
// Shifts in one numerator bit, trial-subtracts the divisor, passes remainder, numerator and quotient on.
// ----------------------------------------------------------------------------
module rmq_div_cell #(
    parameter int DIV_W = rmq_pkg::ROOT_W_DEF,
    parameter int QUO_W = rmq_pkg::QUO_W_DEF
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [DIV_W-1:0] i_div,
    input  logic [DIV_W-1:0] i_rem,
    input  logic [QUO_W-1:0] i_num,
    input  logic [QUO_W-1:0] i_quo,
    output logic [DIV_W-1:0] o_rem,
    output logic [QUO_W-1:0] o_num,
    output logic [QUO_W-1:0] o_quo
);
    logic [DIV_W:0]   w_cat;
    logic [DIV_W+1:0] w_diff;
    logic             w_take;
    logic [DIV_W-1:0] n_rem, r_rem;
    logic [QUO_W-1:0] n_num, r_num;
    logic [QUO_W-1:0] n_quo, r_quo;

    always_comb begin
        w_cat  = {i_rem, i_num[QUO_W-1]};
        w_diff = {1'b0, w_cat} - (DIV_W+2)'(i_div);
        w_take = !w_diff[DIV_W+1];
        n_rem  = w_take ? w_diff[DIV_W-1:0] : w_cat[DIV_W-1:0];
        n_quo  = {i_quo[QUO_W-2:0], w_take};
        n_num  = {i_num[QUO_W-2:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_num <= n_num;
            r_quo <= n_quo;
        end
    end

    assign o_rem = r_rem;
    assign o_num = r_num;
    assign o_quo = r_quo;

endmodule

// File: rtl/rotation_matrix_to_quaternion.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion: 3x3 rotation matrix to quaternion converter
// Selects the trace or largest-diagonal branch, takes 2*sqrt of the radicand
// in a chain of root cells, then divides three terms by it in divider cells.
// ----------------------------------------------------------------------------
// Stages from input transfer to output: one front stage, 19 root cells, one
//   numerator stage, 35 divider cells per lane and one output register
//   (cell counts at FRAC_BITS = 16).
// Throughput: one matrix per cycle; every stage advances together and stalls
//   only while a finished result sits in the output register untaken.
// Reset (synchronous, active low) clears all stage valid bits and the output
//   valid, and sets trace_threshold to 1 in raw Q16 units (1/65536).
module rotation_matrix_to_quaternion #(
    parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // APB-style configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [rmq_pkg::ADDR_W-1:0]         paddr,
    input  logic [rmq_pkg::DATA_W-1:0]         pwdata,
    output logic [rmq_pkg::DATA_W-1:0]         prdata,
    output logic                               pready,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m11,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m12,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m13,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m21,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m22,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m23,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m31,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m32,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m33,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_quat_x,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_quat_y,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_quat_z,
    output logic signed [rmq_pkg::FIELD_W-1:0] o_quat_w,
    output logic [1:0]                         o_branch_taken,
    output logic                               o_degenerate
);
    localparam int FIELD_W = rmq_pkg::FIELD_W;
    localparam int MAG_W   = rmq_pkg::MAG_W;
    localparam int LANES   = rmq_pkg::LANES;
    localparam int THR_W   = rmq_pkg::THR_W;
    // trace and radicand span about 2^FRAC_BITS + 3*2^17
    localparam int T_W     = ((FRAC_BITS > 19) ? FRAC_BITS : 19) + 2;
    localparam int R_W     = T_W - 1;
    localparam int RAD_W   = R_W + FRAC_BITS + 2;
    localparam int ROOT_W  = (RAD_W + 1) / 2;
    localparam int SQ_W    = 2 * ROOT_W;
    localparam int REM_W   = ROOT_W + 2;
    localparam int NUM_W   = MAG_W + FRAC_BITS;
    localparam logic signed [T_W-1:0] ONE = T_W'(64'd1 << FRAC_BITS);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [THR_W-1:0] r_thr;
    logic             w_cfg_hit;

    assign w_cfg_hit = (paddr[rmq_pkg::ADDR_W-1] == rmq_pkg::REG_THRESHOLD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= rmq_pkg::THR_RESET;
        end else if (psel && penable && pwrite && pready && w_cfg_hit) begin
            r_thr <= pwdata[THR_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = w_cfg_hit ? rmq_pkg::DATA_W'(r_thr) : '0;

    // ------------------------------------------------------------------
    // Global advance: hold every stage while the output waits
    // ------------------------------------------------------------------
    logic w_en;
    logic r_out_valid;

    assign w_en       = !r_out_valid || i_out_ready;
    assign o_in_ready = w_en;

    // ------------------------------------------------------------------
    // Front stage: branch pick, radicand, the three quotient numerators
    // ------------------------------------------------------------------
    logic signed [T_W-1:0]   w_e11, w_e22, w_e33, w_t, w_rad;
    logic [R_W-1:0]          w_rpos;
    logic signed [MAG_W-1:0] w_d3223, w_d1331, w_d2112;
    logic signed [MAG_W-1:0] w_p2112, w_p1331, w_p3223;
    logic signed [MAG_W-1:0] w_lv [LANES];
    rmq_pkg::t_branch        w_br;
    rmq_pkg::t_tag           n_tag0;
    logic [LANES-1:0][MAG_W-1:0] n_mag0;
    logic [SQ_W-1:0]         n_rad0, r_rad0;

    always_comb begin
        w_e11   = T_W'(i_m11);
        w_e22   = T_W'(i_m22);
        w_e33   = T_W'(i_m33);
        w_t     = ONE + w_e11 + w_e22 + w_e33;
        w_d3223 = MAG_W'(i_m32) - MAG_W'(i_m23);
        w_d1331 = MAG_W'(i_m13) - MAG_W'(i_m31);
        w_d2112 = MAG_W'(i_m21) - MAG_W'(i_m12);
        w_p2112 = MAG_W'(i_m21) + MAG_W'(i_m12);
        w_p1331 = MAG_W'(i_m13) + MAG_W'(i_m31);
        w_p3223 = MAG_W'(i_m32) + MAG_W'(i_m23);

        if (w_t > T_W'(signed'({1'b0, r_thr}))) begin
            w_br = rmq_pkg::BR_TRACE;
        end else if (w_e11 > w_e22 && w_e11 > w_e33) begin
            w_br = rmq_pkg::BR_X;
        end else if (w_e22 > w_e33) begin
            w_br = rmq_pkg::BR_Y;
        end else begin
            w_br = rmq_pkg::BR_Z;
        end

        // lanes hold the three divided components in x, y, z, w order
        case (w_br)
            rmq_pkg::BR_TRACE: begin
                w_rad   = w_t;
                w_lv[0] = w_d3223;
                w_lv[1] = w_d1331;
                w_lv[2] = w_d2112;
            end
            rmq_pkg::BR_X: begin
                w_rad   = ONE + w_e11 - w_e22 - w_e33;
                w_lv[0] = w_p2112;
                w_lv[1] = w_p1331;
                w_lv[2] = w_d3223;
            end
            rmq_pkg::BR_Y: begin
                w_rad   = ONE + w_e22 - w_e11 - w_e33;
                w_lv[0] = w_p2112;
                w_lv[1] = w_p3223;
                w_lv[2] = w_d1331;
            end
            default: begin
                w_rad   = ONE + w_e33 - w_e11 - w_e22;
                w_lv[0] = w_p1331;
                w_lv[1] = w_p3223;
                w_lv[2] = w_d2112;
            end
        endcase

        // a negative radicand counts as zero, which forces s to zero
        w_rpos = (w_rad > 0) ? w_rad[R_W-1:0] : '0;
        n_rad0 = SQ_W'({w_rpos, {(FRAC_BITS + 2){1'b0}}});

        n_tag0.branch = w_br;
        n_tag0.degen  = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            n_tag0.neg[l] = w_lv[l][MAG_W-1];
            n_mag0[l]     = w_lv[l][MAG_W-1] ? MAG_W'(-w_lv[l]) : MAG_W'(w_lv[l]);
        end
    end

    // ------------------------------------------------------------------
    // Square-root chain: one root bit per cell
    // ------------------------------------------------------------------
    logic [REM_W-1:0]            w_sq_rem  [0:ROOT_W];
    logic [ROOT_W-1:0]           w_sq_root [0:ROOT_W];
    logic [SQ_W-1:0]             w_sq_rad  [0:ROOT_W];
    rmq_pkg::t_tag               r_sq_tag  [0:ROOT_W];
    logic [LANES-1:0][MAG_W-1:0] r_sq_mag  [0:ROOT_W];
    logic [ROOT_W:0]             r_sq_vld;

    assign w_sq_rem[0]  = '0;
    assign w_sq_root[0] = '0;
    assign w_sq_rad[0]  = r_rad0;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rad0      <= n_rad0;
            r_sq_tag[0] <= n_tag0;
            r_sq_mag[0] <= n_mag0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_vld <= '0;
        end else if (w_en) begin
            r_sq_vld <= {r_sq_vld[ROOT_W-1:0], i_in_valid};
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
        rmq_sqrt_cell #(
            .ROOT_W (ROOT_W)
        ) u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_sq_rem[k]),
            .i_root (w_sq_root[k]),
            .i_rad  (w_sq_rad[k]),
            .o_rem  (w_sq_rem[k+1]),
            .o_root (w_sq_root[k+1]),
            .o_rad  (w_sq_rad[k+1])
        );

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_sq_tag[k+1] <= r_sq_tag[k];
                r_sq_mag[k+1] <= r_sq_mag[k];
            end
        end
    end

    // ------------------------------------------------------------------
    // Numerator stage: |d| << FRAC_BITS plus s/2 for round to nearest
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] w_s;
    rmq_pkg::t_tag     n_tag_nm;
    logic [NUM_W-1:0]  n_num [LANES];
    logic [NUM_W-1:0]  r_num [LANES];

    assign w_s = w_sq_root[ROOT_W];

    always_comb begin
        n_tag_nm       = r_sq_tag[ROOT_W];
        n_tag_nm.degen = (w_s == '0);
        for (int l = 0; l < LANES; l++) begin
            n_num[l] = (NUM_W'(r_sq_mag[ROOT_W][l]) << FRAC_BITS) + NUM_W'(w_s >> 1);
        end
    end

    // ------------------------------------------------------------------
    // Divider chain: three lanes of cells share the divisor per stage
    // ------------------------------------------------------------------
    logic [ROOT_W-1:0] w_dv_rem [0:NUM_W][LANES];
    logic [NUM_W-1:0]  w_dv_num [0:NUM_W][LANES];
    logic [NUM_W-1:0]  w_dv_quo [0:NUM_W][LANES];
    logic [ROOT_W-1:0] r_dv_s   [0:NUM_W];
    rmq_pkg::t_tag     r_dv_tag [0:NUM_W];
    logic [NUM_W:0]    r_dv_vld;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dv_s[0]   <= w_s;
            r_dv_tag[0] <= n_tag_nm;
            for (int l = 0; l < LANES; l++) begin
                r_num[l] <= n_num[l];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= '0;
        end else if (w_en) begin
            r_dv_vld <= {r_dv_vld[NUM_W-1:0], r_sq_vld[ROOT_W]};
        end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane_in
        assign w_dv_rem[0][l] = '0;
        assign w_dv_quo[0][l] = '0;
        assign w_dv_num[0][l] = r_num[l];
    end

    for (genvar j = 0; j < NUM_W; j++) begin : g_div
        for (genvar l = 0; l < LANES; l++) begin : g_lane
            rmq_div_cell #(
                .DIV_W (ROOT_W),
                .QUO_W (NUM_W)
            ) u_cell (
                .i_clk (i_clk),
                .i_en  (w_en),
                .i_div (r_dv_s[j]),
                .i_rem (w_dv_rem[j][l]),
                .i_num (w_dv_num[j][l]),
                .i_quo (w_dv_quo[j][l]),
                .o_rem (w_dv_rem[j+1][l]),
                .o_num (w_dv_num[j+1][l]),
                .o_quo (w_dv_quo[j+1][l])
            );
        end

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_dv_s[j+1]   <= r_dv_s[j];
                r_dv_tag[j+1] <= r_dv_tag[j];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stage: saturate, place the quarter term, zero on degenerate
    // ------------------------------------------------------------------
    function automatic logic signed [FIELD_W-1:0] f_sat_quo(
        input logic [NUM_W-1:0] q,
        input logic             neg
    );
        logic signed [FIELD_W-1:0] lo;
        lo = signed'(q[FIELD_W-1:0]);
        if (!neg) begin
            return (64'(q) > 64'(rmq_pkg::SAT_MAX)) ? rmq_pkg::Q_MAX : lo;
        end
        return (64'(q) > 64'(rmq_pkg::SAT_MIN_MAG)) ? rmq_pkg::Q_MIN : -lo;
    endfunction

    rmq_pkg::t_tag             w_otag;
    logic [ROOT_W:0]           w_qsum;
    logic signed [FIELD_W-1:0] w_qtr;
    logic signed [FIELD_W-1:0] w_ql [LANES];
    logic signed [FIELD_W-1:0] n_x, n_y, n_z, n_w;
    logic signed [FIELD_W-1:0] r_x, r_y, r_z, r_w;
    logic [1:0]                r_branch;
    logic                      r_degen;

    always_comb begin
        w_otag = r_dv_tag[NUM_W];
        w_qsum = {1'b0, r_dv_s[NUM_W]} + (ROOT_W+1)'(2);
        w_qtr  = (64'(w_qsum >> 2) > 64'(rmq_pkg::SAT_MAX)) ? rmq_pkg::Q_MAX
               : FIELD_W'(w_qsum >> 2);
        for (int l = 0; l < LANES; l++) begin
            w_ql[l] = f_sat_quo(w_dv_quo[NUM_W][l], w_otag.neg[l]);
        end
        case (w_otag.branch)
            rmq_pkg::BR_TRACE: begin
                n_x = w_ql[0]; n_y = w_ql[1]; n_z = w_ql[2]; n_w = w_qtr;
            end
            rmq_pkg::BR_X: begin
                n_x = w_qtr;   n_y = w_ql[0]; n_z = w_ql[1]; n_w = w_ql[2];
            end
            rmq_pkg::BR_Y: begin
                n_x = w_ql[0]; n_y = w_qtr;   n_z = w_ql[1]; n_w = w_ql[2];
            end
            default: begin
                n_x = w_ql[0]; n_y = w_ql[1]; n_z = w_qtr;   n_w = w_ql[2];
            end
        endcase
        if (w_otag.degen) begin
            n_x = '0; n_y = '0; n_z = '0; n_w = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x      <= n_x;
            r_y      <= n_y;
            r_z      <= n_z;
            r_w      <= n_w;
            r_branch <= w_otag.branch;
            r_degen  <= w_otag.degen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_dv_vld[NUM_W];
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_quat_x       = r_x;
    assign o_quat_y       = r_y;
    assign o_quat_z       = r_z;
    assign o_quat_w       = r_w;
    assign o_branch_taken = r_branch;
    assign o_degenerate   = r_degen;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid survived reset");

    a_transfer_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> r_sq_vld[0])
        else $error("accepted transfer did not enter the front stage");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_degenerate |->
            o_quat_x == '0 && o_quat_y == '0 && o_quat_z == '0 && o_quat_w == '0)
        else $error("degenerate result carries nonzero components");

    a_trace_w_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_branch_taken == rmq_pkg::BR_TRACE |-> !o_quat_w[FIELD_W-1])
        else $error("trace branch produced negative w");

endmodule

// File: tb/rmq_checker.sv
// ----------------------------------------------------------------------------
// rmq_checker: quaternion predictor and result comparator
// Watches both channels of the converter, computes the expected quaternion for
// every accepted matrix and compares each accepted result, field by field.
// ----------------------------------------------------------------------------
module rmq_checker (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [rmq_pkg::THR_W-1:0]          i_threshold,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_m [9],
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_qx,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_qy,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_qz,
    input  logic signed [rmq_pkg::FIELD_W-1:0] i_qw,
    input  logic [1:0]                         i_branch,
    input  logic                               i_degen,
    output int                                 o_errors,
    output int                                 o_pending,
    output int                                 o_results,
    output int                                 o_degen_seen,
    output int                                 o_branch_seen [4]
);
    localparam int FIELD_W       = rmq_pkg::FIELD_W;
    localparam int THR_W         = rmq_pkg::THR_W;
    localparam int FRAC_BITS_DEF = rmq_pkg::FRAC_BITS_DEF;
    localparam int SAT_MAX       = rmq_pkg::SAT_MAX;
    localparam int SAT_MIN_MAG   = rmq_pkg::SAT_MIN_MAG;

    typedef struct {
        logic signed [FIELD_W-1:0] qx, qy, qz, qw;
        rmq_pkg::t_branch          br;
        logic                      degen;
    } t_quat;

    t_quat quat_queue[$];

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned root, step;
        root = 0;
        step = 64'd1 << 62;
        while (step > n) step >>= 2;
        while (step != 0) begin
            if (n >= root + step) begin
                n -= root + step;
                root = (root >> 1) + step;
            end else begin
                root >>= 1;
            end
            step >>= 2;
        end
        return root;
    endfunction

    function automatic longint unsigned twice_root(longint r);
        if (r <= 0) return 0;
        return int_sqrt(longint'(r) << (FRAC_BITS_DEF + 2));
    endfunction

    function automatic longint clamp(longint v);
        if (v > SAT_MAX) return SAT_MAX;
        if (v < -SAT_MIN_MAG) return -SAT_MIN_MAG;
        return v;
    endfunction

    function automatic longint ratio(longint d, longint unsigned s);
        longint unsigned mag, q;
        mag = (d < 0) ? longint'(-d) : d;
        q = ((mag << FRAC_BITS_DEF) + (s >> 1)) / s;
        if (q > (64'd1 << 40)) q = 64'd1 << 40;
        return clamp((d < 0) ? -longint'(q) : longint'(q));
    endfunction

    function automatic t_quat predict_quat(logic signed [FIELD_W-1:0] m [9],
                                           logic [THR_W-1:0] thr);
        longint a [9];
        longint one, t, x, y, z, w;
        longint unsigned s;
        t_quat res;
        one = 64'sd1 << FRAC_BITS_DEF;
        foreach (m[k]) a[k] = m[k];
        t = one + a[0] + a[4] + a[8];
        if (t > longint'(thr)) begin
            res.br = rmq_pkg::BR_TRACE; s = twice_root(t);
        end else if (a[0] > a[4] && a[0] > a[8]) begin
            res.br = rmq_pkg::BR_X; s = twice_root(one + a[0] - a[4] - a[8]);
        end else if (a[4] > a[8]) begin
            res.br = rmq_pkg::BR_Y; s = twice_root(one + a[4] - a[0] - a[8]);
        end else begin
            res.br = rmq_pkg::BR_Z; s = twice_root(one + a[8] - a[0] - a[4]);
        end
        res.degen = (s == 0);
        if (s == 0) begin
            x = 0; y = 0; z = 0; w = 0;
        end else begin
            case (res.br)
                rmq_pkg::BR_TRACE: begin
                    x = ratio(a[7] - a[5], s); y = ratio(a[2] - a[6], s);
                    z = ratio(a[3] - a[1], s); w = clamp((s + 2) >> 2);
                end
                rmq_pkg::BR_X: begin
                    x = clamp((s + 2) >> 2); y = ratio(a[3] + a[1], s);
                    z = ratio(a[2] + a[6], s); w = ratio(a[7] - a[5], s);
                end
                rmq_pkg::BR_Y: begin
                    x = ratio(a[3] + a[1], s); y = clamp((s + 2) >> 2);
                    z = ratio(a[7] + a[5], s); w = ratio(a[2] - a[6], s);
                end
                default: begin
                    x = ratio(a[2] + a[6], s); y = ratio(a[7] + a[5], s);
                    z = clamp((s + 2) >> 2); w = ratio(a[3] - a[1], s);
                end
            endcase
        end
        res.qx = x[FIELD_W-1:0]; res.qy = y[FIELD_W-1:0];
        res.qz = z[FIELD_W-1:0]; res.qw = w[FIELD_W-1:0];
        return res;
    endfunction

    initial begin
        o_errors = 0;
        o_results = 0;
        o_degen_seen = 0;
        foreach (o_branch_seen[k]) o_branch_seen[k] = 0;
    end

    assign o_pending = quat_queue.size();

    always @(posedge i_clk) begin
        t_quat got, want;
        if (i_rst_n && i_in_valid && i_in_ready)
            quat_queue.push_back(predict_quat(i_m, i_threshold));
        if (i_rst_n && i_out_valid && i_out_ready) begin
            got.qx = i_qx; got.qy = i_qy; got.qz = i_qz; got.qw = i_qw;
            got.br = rmq_pkg::t_branch'(i_branch); got.degen = i_degen;
            o_results++;
            o_branch_seen[i_branch]++;
            if (i_degen) o_degen_seen++;
            if (quat_queue.size() == 0) begin
                $error("unexpected result transfer");
                o_errors++;
            end else begin
                want = quat_queue.pop_front();
                if (got.qx !== want.qx) begin
                    $error("quat_x expected %0d got %0d", want.qx, got.qx); o_errors++;
                end
                if (got.qy !== want.qy) begin
                    $error("quat_y expected %0d got %0d", want.qy, got.qy); o_errors++;
                end
                if (got.qz !== want.qz) begin
                    $error("quat_z expected %0d got %0d", want.qz, got.qz); o_errors++;
                end
                if (got.qw !== want.qw) begin
                    $error("quat_w expected %0d got %0d", want.qw, got.qw); o_errors++;
                end
                if (got.br !== want.br) begin
                    $error("branch_taken expected %0d got %0d", want.br, got.br);
                    o_errors++;
                end
                if (got.degen !== want.degen) begin
                    $error("degenerate expected %0d got %0d", want.degen, got.degen);
                    o_errors++;
                end
            end
        end
    end

endmodule

// File: tb/rotation_matrix_to_quaternion_test.sv
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_test: stimulus and verdict for the converter
// Sends directed and random matrices under several trace thresholds, with
// random gaps on both channels and one long output hold-off; the checker
// predicts and compares every quaternion.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_test;
    localparam int ADDR_W     = rmq_pkg::ADDR_W;
    localparam int DATA_W     = rmq_pkg::DATA_W;
    localparam int FIELD_W    = rmq_pkg::FIELD_W;
    localparam int THR_W      = rmq_pkg::THR_W;
    localparam int LATENCY    = 57;
    localparam int WDOG_LIMIT = 20000;
    localparam int RANDOM_CNT = 1530;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata, prdata;
    logic pready;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [FIELD_W-1:0] mat [9];
    logic signed [FIELD_W-1:0] qx, qy, qz, qw;
    logic [1:0] branch;
    logic degen;

    // Mirror of the threshold register, sampled by the checker at each input transfer
    logic [THR_W-1:0] threshold;

    int errors, pending, results, degen_seen;
    int branch_seen [4];
    int idle_cycles;
    bit hold_off;

    rotation_matrix_to_quaternion dut (
        .i_clk, .i_rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_m11(mat[0]), .i_m12(mat[1]), .i_m13(mat[2]),
        .i_m21(mat[3]), .i_m22(mat[4]), .i_m23(mat[5]),
        .i_m31(mat[6]), .i_m32(mat[7]), .i_m33(mat[8]),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_quat_x(qx), .o_quat_y(qy), .o_quat_z(qz), .o_quat_w(qw),
        .o_branch_taken(branch), .o_degenerate(degen)
    );

    rmq_checker u_checker (
        .i_clk, .i_rst_n, .i_threshold(threshold),
        .i_in_valid(in_valid), .i_in_ready(in_ready), .i_m(mat),
        .i_out_valid(out_valid), .i_out_ready(out_ready),
        .i_qx(qx), .i_qy(qy), .i_qz(qz), .i_qw(qw),
        .i_branch(branch), .i_degen(degen),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_degen_seen(degen_seen), .o_branch_seen(branch_seen)
    );

    initial begin
        i_clk = 0;
        forever #4 i_clk = ~i_clk;
    end

    // Drive every input known from time zero
    initial begin
        i_rst_n = 0; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        in_valid = 0; out_ready = 0; threshold = rmq_pkg::THR_RESET; hold_off = 0;
        foreach (mat[k]) mat[k] = '0;
    end

    // Watchdog: count cycles with no transfer on either channel
    always @(posedge i_clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stall before each transfer, and ready stays low while held off
    initial begin
        int gap;
        idle_cycles = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 17);
            if (hold_off || gap != 0) begin
                out_ready <= 0;
                repeat (gap) @(posedge i_clk);
                while (hold_off) @(posedge i_clk);
            end
            out_ready <= 1;
            @(posedge i_clk iff out_valid);
        end
    end

    // Write the threshold register: setup cycle, then access cycle
    task automatic write_threshold(logic [THR_W-1:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {rmq_pkg::REG_THRESHOLD, {(ADDR_W-1){1'b0}}};
        pwdata <= DATA_W'(value);
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk iff pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        threshold <= value;
        @(posedge i_clk);
    endtask

    // Write the unused register slot; the threshold must not move
    task automatic write_unused(logic [DATA_W-1:0] value);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {1'b1, {(ADDR_W-1){1'b0}}};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk iff pready);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // Offer one matrix after a random gap (none if no_gap) and hold it until the transfer
    task automatic send_matrix(logic signed [FIELD_W-1:0] m [9], bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 17));
        if (gap != 0) begin
            in_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1;
        foreach (m[k]) mat[k] <= m[k];
        @(posedge i_clk iff in_ready);
    endtask

    task automatic drop_valid();
        in_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic drain();
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    function automatic logic signed [FIELD_W-1:0] rand_elem();
        case ($urandom_range(0, 9))
            0: return FIELD_W'(65536);
            1: return FIELD_W'(-65536);
            2: return rmq_pkg::Q_MAX;
            3: return rmq_pkg::Q_MIN;
            4: return FIELD_W'($urandom());
            5: return '0;
            default: return FIELD_W'($signed($urandom_range(0, 131072)) - 65536);
        endcase
    endfunction

    // Mostly rotation-like: random dominant diagonal, small off-diagonals; else all random
    task automatic make_matrix(output logic signed [FIELD_W-1:0] m [9]);
        int pick;
        if ($urandom_range(0, 3) == 0) begin
            foreach (m[k]) m[k] = rand_elem();
        end else begin
            pick = $urandom_range(0, 3);
            foreach (m[k]) m[k] = FIELD_W'($signed($urandom_range(0, 60000)) - 30000);
            for (int d = 0; d < 3; d++)
                m[d * 4] = FIELD_W'($signed($urandom_range(0, 40000)) - 65536);
            if (pick != 0) m[(pick - 1) * 4] = FIELD_W'($urandom_range(20000, 65536));
            else for (int d = 0; d < 3; d++) m[d * 4] = FIELD_W'($urandom_range(0, 65536));
        end
    endtask

    initial begin
        logic signed [FIELD_W-1:0] m [9];
        logic [THR_W-1:0] thr_set [5];
        thr_set = '{THR_W'(0), THR_W'(65536), THR_W'(131071), THR_W'(1),
                    THR_W'(32768)};
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: identity, 180-degree turns, extremes and all-ones
        write_unused('1);
        foreach (m[k]) m[k] = '0;
        m[0] = FIELD_W'(65536); m[4] = FIELD_W'(65536); m[8] = FIELD_W'(65536);
        send_matrix(m, 0);
        for (int d = 0; d < 3; d++) begin
            foreach (m[k]) m[k] = '0;
            foreach (m[k]) if (k % 4 == 0) m[k] = FIELD_W'(-65536);
            m[d * 4] = FIELD_W'(65536);
            send_matrix(m, 0);
        end
        foreach (m[k]) m[k] = '0;
        m[0] = FIELD_W'(-65536); m[4] = FIELD_W'(-65536); m[8] = FIELD_W'(-65536);
        send_matrix(m, 0);                                  // tied diagonal, z branch
        foreach (m[k]) m[k] = rmq_pkg::Q_MAX;
        send_matrix(m, 0);
        foreach (m[k]) m[k] = rmq_pkg::Q_MIN;
        send_matrix(m, 0);
        foreach (m[k]) m[k] = (k % 2) ? rmq_pkg::Q_MAX : rmq_pkg::Q_MIN;
        send_matrix(m, 0);
        foreach (m[k]) m[k] = (k % 2) ? rmq_pkg::Q_MIN : rmq_pkg::Q_MAX;
        send_matrix(m, 0);
        foreach (m[k]) m[k] = FIELD_W'(-1);
        send_matrix(m, 0);
        foreach (m[k]) m[k] = '0;
        m[1] = rmq_pkg::Q_MAX; m[3] = rmq_pkg::Q_MIN;      // z branch, large off-diagonal terms
        m[0] = FIELD_W'(-65535);
        send_matrix(m, 0);
        foreach (m[k]) m[k] = '0;                            // t = one, above the reset threshold of 1 raw
        send_matrix(m, 0);
        drop_valid();
        drain();

        // Random phases across threshold settings
        for (int p = 0; p < 5; p++) begin
            write_threshold(thr_set[p]);
            for (int n = 0; n < RANDOM_CNT / 5; n++) begin
                // Long output hold-off in the middle phase while input keeps coming
                if (p == 2 && n == 10) begin
                    hold_off = 1;
                    fork
                        begin
                            repeat (300) @(posedge i_clk);
                            hold_off = 0;
                        end
                    join_none
                end
                make_matrix(m);
                send_matrix(m, (n % 200) < 30 || hold_off);
            end
            drop_valid();
            drain();
        end

        $display("Converted %0d matrices: trace %0d, x %0d, y %0d, z %0d branches,",
                 results, branch_seen[0], branch_seen[1], branch_seen[2], branch_seen[3]);
        $display("%0d degenerate, under 5 thresholds from 0 to 131071.", degen_seen);
        if (errors == 0 && pending == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
